@@ src/pta_pkg.sv @@
`default_nettype none

package pta_pkg;

    localparam int FUNC_W = 3;
    localparam int IDX_W  = 3;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 4;
    localparam int S_TDATA_W = 40;
    localparam int TDATA_W = 48;

    typedef enum logic [FUNC_W-1:0] {
        FN_SAVE    = 3'd0,
        FN_DELETE  = 3'd1,
        FN_EVAL    = 3'd2,
        FN_SUM     = 3'd3,
        FN_SCALE   = 3'd4,
        FN_MUL     = 3'd5,
        FN_COMPOSE = 3'd6
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_INDEX = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_DEG_OVF   = 2'd3
    } stat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DEG_A,
        S_DEG_B,
        S_DEG_CHK,
        S_DISPATCH,
        S_PLAN,
        S_CLEAR,
        S_PASS_RD,
        S_PASS_MUL,
        S_PASS_WR,
        S_EVAL_RD,
        S_EVAL_MUL,
        S_EVAL_WR,
        S_COMMIT_RD,
        S_COMMIT_WR,
        S_DEL_CHK,
        S_DEL_RD,
        S_DEL_WR,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        M_ONE,
        M_OPV,
        M_COEF
    } msel_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  first_index;
        logic [IDX_W-1:0]  second_index;
        logic [VAL_W-1:0]  operand_value;
        logic              last_coef;
    } item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  result_value;
        logic [IDX_W-1:0]  new_index;
        logic [CNT_W-1:0]  table_count;
    } result_t;

endpackage

`default_nettype wire

@@ src/polynomial_table_alu_top.sv @@
// save and unused codes: go straight from idle to the response state, then to the output register
// evaluate: horner, a read, multiply and write step per coefficient on the shared multiply-add unit
// sum, scale, multiply: scratch clear, multiply-add passes (read, multiply, write), then a copy of each coefficient
// compose: horner over p1, each step a scratch clear plus multiply-add passes
// delete: read then write per coefficient, 16 coefficients per shifted entry; one word in work at a time
// reset: rst_n asynchronous active low clears count, open save run and handshakes

`default_nettype none

module polynomial_table_alu_top
import pta_pkg::*;
#(
    parameter int MAX_POLYS  = 8,
    parameter int MAX_DEGREE = 15,
    parameter int COEF_WIDTH = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // first_index, second_index, operand_value, zero fill
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // func
    input  wire logic [FUNC_W-1:0]    s_axis_tuser,
    input  wire logic                 s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // status, result_value, new_index, table_count, zero fill
    output logic [TDATA_W-1:0]        m_axis_tdata
);

    item_t   item;
    result_t res;
    logic    core_idle, res_valid, res_ready, start;
    logic    out_valid_reg;
    result_t out_reg;

    assign item.func          = s_axis_tuser;
    assign item.first_index   = s_axis_tdata[2:0];
    assign item.second_index  = s_axis_tdata[5:3];
    assign item.operand_value = s_axis_tdata[37:6];
    assign item.last_coef     = s_axis_tlast;

    assign s_axis_tready = core_idle;
    assign start         = s_axis_tvalid && core_idle;
    assign res_ready     = !out_valid_reg || m_axis_tready;

    pta_core #(
        .MAX_POLYS  (MAX_POLYS),
        .MAX_DEGREE (MAX_DEGREE),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .idle      (core_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_reg.table_count, out_reg.new_index,
                            out_reg.result_value, out_reg.status};

endmodule

`default_nettype wire

@@ src/pta_mac.sv @@
`default_nettype none

module pta_mac
#(
    parameter int W = 32
)
(
    input  wire logic         clk,
    input  wire logic         load,
    input  wire logic [W-1:0] mul_a,
    input  wire logic [W-1:0] mul_b,
    input  wire logic [W-1:0] addend,
    output logic      [W-1:0] sum
);

    logic [W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= W'(mul_a * mul_b);
        end
    end

    assign sum = addend + prod_reg;

endmodule

`default_nettype wire

@@ src/pta_core.sv @@
`default_nettype none

module pta_core
import pta_pkg::*;
#(
    parameter int MAX_POLYS  = 8,
    parameter int MAX_DEGREE = 15,
    parameter int COEF_WIDTH = 32
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire item_t   item,
    output logic         idle,
    output logic         res_valid,
    input  wire logic    res_ready,
    output result_t      res
);

    localparam int STRIDE = MAX_DEGREE + 1;
    localparam int PW     = (MAX_POLYS > 1) ? $clog2(MAX_POLYS) : 1;
    localparam int CW     = $clog2(MAX_POLYS + 1);
    localparam int DW     = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE + 1) : 1;
    localparam int PLW    = $clog2(MAX_DEGREE + 2);
    localparam int CMPW   = (CW > IDX_W) ? CW : IDX_W;
    localparam int DGW    = 2 * DW + 1;

    state_t state_reg, state_next;

    logic [FUNC_W-1:0]     func_reg;
    logic [PW-1:0]         a_reg, b_reg, row_reg, src_poly_reg, nidx_reg;
    logic [COEF_WIDTH-1:0] opv_reg, acc_reg;
    logic [CW-1:0]         count_reg;
    logic [PLW-1:0]        pend_reg;
    stat_t                 status_reg;
    logic [VAL_W-1:0]      rval_reg;
    logic [DW-1:0]         da_reg, db_reg, deg_reg, r_reg, i_reg;
    logic [DW-1:0]         k_reg, j_reg, klo_reg, khi_reg, jhi_reg;
    logic [1:0]            phase_reg;
    logic                  bank_reg, first_reg, src_coef_reg;
    msel_t                 msel_reg;

    logic [COEF_WIDTH-1:0] coef_mem [MAX_POLYS][STRIDE];
    logic [DW-1:0]         deg_mem [MAX_POLYS];
    logic [COEF_WIDTH-1:0] scr_mem [2][STRIDE];

    logic [COEF_WIDTH-1:0] ca_rd_reg, cb_rd_reg, sx_rd_reg, sy_rd_reg;
    logic [DW-1:0]         dg_rd_reg;

    logic                  op_in, two_in, bad_idx, full, pend_ovf, save_ok;
    logic [COEF_WIDTH-1:0] item_opv;
    logic [DGW-1:0]        deg_calc;
    logic                  deg_ovf;
    logic [DW-1:0]         dst_k, kmax;
    logic [PW-1:0]         row_next_idx;

    logic [PW-1:0]         ca_poly;
    logic [DW-1:0]         ca_k;
    logic [PW-1:0]         dg_addr;
    logic                  coef_we, deg_we, scr_we, mac_load;
    logic [PW-1:0]         coef_wpoly, deg_waddr;
    logic [DW-1:0]         coef_wk, scr_wk, deg_wdata;
    logic [COEF_WIDTH-1:0] coef_wdata, scr_wdata;
    logic [COEF_WIDTH-1:0] mac_a, mac_b, mac_add, mac_sum, src_data;

    assign kmax     = DW'(MAX_DEGREE);
    assign item_opv = COEF_WIDTH'($signed(item.operand_value));
    assign op_in    = (item.func != FN_SAVE) && (item.func <= FN_COMPOSE);
    assign two_in   = (item.func == FN_SUM) || (item.func == FN_MUL)
                   || (item.func == FN_COMPOSE);
    assign bad_idx  = (CMPW'(item.first_index) >= CMPW'(count_reg))
                   || (two_in && (CMPW'(item.second_index) >= CMPW'(count_reg)));
    assign full     = count_reg >= CW'(MAX_POLYS);
    assign pend_ovf = pend_reg > PLW'(MAX_DEGREE);
    assign save_ok  = start && (item.func == FN_SAVE) && !full && !pend_ovf;
    assign dst_k    = DW'((k_reg - klo_reg) + j_reg);
    assign row_next_idx = PW'(CW'(row_reg) + CW'(1));
    assign src_data = src_coef_reg ? ca_rd_reg : sx_rd_reg;

    always_comb
    begin
        unique case (func_reg)
            FN_SUM:     deg_calc = DGW'((da_reg > db_reg) ? da_reg : db_reg);
            FN_MUL:     deg_calc = DGW'(da_reg) + DGW'(db_reg);
            FN_COMPOSE: deg_calc = DGW'(da_reg) * DGW'(db_reg);
            default:    deg_calc = DGW'(da_reg);
        endcase
    end

    assign deg_ovf = deg_calc > DGW'(MAX_DEGREE);

    pta_mac #(.W(COEF_WIDTH)) u_mac (
        .clk    (clk),
        .load   (mac_load),
        .mul_a  (mac_a),
        .mul_b  (mac_b),
        .addend (mac_add),
        .sum    (mac_sum)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (!op_in || bad_idx)
                        state_next = S_RESP;
                    else if (item.func == FN_DELETE)
                        state_next = S_DEL_CHK;
                    else
                        state_next = S_DEG_A;
                end
            end
            S_DEG_A:    state_next = S_DEG_B;
            S_DEG_B:    state_next = S_DEG_CHK;
            S_DEG_CHK:  state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                if (func_reg == FN_EVAL)
                    state_next = S_EVAL_RD;
                else if (full || deg_ovf)
                    state_next = S_RESP;
                else
                    state_next = S_PLAN;
            end
            S_PLAN:
            begin
                if (phase_reg == 2'd0)
                    state_next = S_CLEAR;
                else if (func_reg == FN_COMPOSE)
                begin
                    if (phase_reg == 2'd1)
                        state_next = first_reg ? S_PLAN : S_PASS_RD;
                    else if (phase_reg == 2'd2)
                        state_next = S_PASS_RD;
                    else
                        state_next = (i_reg == '0) ? S_COMMIT_RD : S_PLAN;
                end
                else if (phase_reg == 2'd1 || (func_reg == FN_SUM && phase_reg == 2'd2))
                    state_next = S_PASS_RD;
                else
                    state_next = S_COMMIT_RD;
            end
            S_CLEAR:     state_next = (k_reg == kmax) ? S_PLAN : S_CLEAR;
            S_PASS_RD:   state_next = S_PASS_MUL;
            S_PASS_MUL:  state_next = S_PASS_WR;
            S_PASS_WR:
                state_next = (j_reg == jhi_reg && k_reg == khi_reg) ? S_PLAN : S_PASS_RD;
            S_EVAL_RD:   state_next = S_EVAL_MUL;
            S_EVAL_MUL:  state_next = S_EVAL_WR;
            S_EVAL_WR:   state_next = (k_reg == '0) ? S_RESP : S_EVAL_RD;
            S_COMMIT_RD: state_next = S_COMMIT_WR;
            S_COMMIT_WR: state_next = (k_reg == deg_reg) ? S_RESP : S_COMMIT_RD;
            S_DEL_CHK:
                state_next = (CW'(row_reg) + CW'(1) >= count_reg) ? S_RESP : S_DEL_RD;
            S_DEL_RD:    state_next = S_DEL_WR;
            S_DEL_WR:    state_next = (k_reg == kmax) ? S_DEL_CHK : S_DEL_RD;
            S_RESP:      state_next = res_ready ? S_IDLE : S_RESP;
            default:     state_next = S_IDLE;
        endcase
    end

    // memory and unit controls
    always_comb
    begin
        ca_poly    = src_poly_reg;
        ca_k       = k_reg;
        dg_addr    = a_reg;
        coef_we    = 1'b0;
        coef_wpoly = PW'(count_reg);
        coef_wk    = k_reg;
        coef_wdata = sx_rd_reg;
        deg_we     = 1'b0;
        deg_waddr  = PW'(count_reg);
        deg_wdata  = deg_reg;
        scr_we     = 1'b0;
        scr_wk     = k_reg;
        scr_wdata  = '0;
        mac_load   = 1'b0;
        mac_a      = src_data;
        mac_add    = sy_rd_reg;
        unique case (msel_reg)
            M_ONE:   mac_b = COEF_WIDTH'(1);
            M_OPV:   mac_b = opv_reg;
            default: mac_b = cb_rd_reg;
        endcase
        unique case (state_reg)
            S_IDLE:
            begin
                if (save_ok)
                begin
                    coef_we    = 1'b1;
                    coef_wk    = DW'(pend_reg);
                    coef_wdata = item_opv;
                    deg_we     = item.last_coef;
                    deg_wdata  = DW'(pend_reg);
                end
            end
            S_DEG_B: dg_addr = b_reg;
            S_CLEAR: scr_we = 1'b1;
            S_PASS_MUL: mac_load = 1'b1;
            S_PASS_WR:
            begin
                scr_we    = 1'b1;
                scr_wk    = dst_k;
                scr_wdata = mac_sum;
            end
            S_EVAL_RD, S_EVAL_MUL, S_EVAL_WR:
            begin
                ca_poly  = a_reg;
                mac_a    = acc_reg;
                mac_b    = opv_reg;
                mac_add  = ca_rd_reg;
                mac_load = (state_reg == S_EVAL_MUL);
            end
            S_COMMIT_WR:
            begin
                coef_we = 1'b1;
                deg_we  = (k_reg == deg_reg);
            end
            S_DEL_RD, S_DEL_WR:
            begin
                ca_poly    = row_next_idx;
                dg_addr    = row_next_idx;
                coef_wpoly = row_reg;
                coef_wdata = ca_rd_reg;
                deg_waddr  = row_reg;
                deg_wdata  = dg_rd_reg;
                coef_we    = (state_reg == S_DEL_WR);
                deg_we     = (state_reg == S_DEL_WR) && (k_reg == kmax);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[coef_wpoly][coef_wk] <= coef_wdata;
        ca_rd_reg <= coef_mem[ca_poly][ca_k];
        cb_rd_reg <= coef_mem[b_reg][j_reg];
    end

    always_ff @(posedge clk)
    begin
        if (deg_we)
            deg_mem[deg_waddr] <= deg_wdata;
        dg_rd_reg <= deg_mem[dg_addr];
    end

    always_ff @(posedge clk)
    begin
        if (scr_we)
            scr_mem[~bank_reg][scr_wk] <= scr_wdata;
        sx_rd_reg <= scr_mem[bank_reg][k_reg];
        sy_rd_reg <= scr_mem[~bank_reg][dst_k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (start && item.func == FN_SAVE)
            begin
                if (!save_ok || item.last_coef)
                    pend_reg <= '0;
                else
                    pend_reg <= pend_reg + PLW'(1);
                if (save_ok && item.last_coef)
                    count_reg <= count_reg + CW'(1);
            end
            else if (start && op_in)
                pend_reg <= '0;
            if (state_reg == S_COMMIT_WR && k_reg == deg_reg)
                count_reg <= count_reg + CW'(1);
            if (state_reg == S_DEL_CHK && (CW'(row_reg) + CW'(1) >= count_reg))
                count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_reg   <= item.func;
                    a_reg      <= PW'(item.first_index);
                    b_reg      <= PW'(item.second_index);
                    row_reg    <= PW'(item.first_index);
                    opv_reg    <= item_opv;
                    rval_reg   <= '0;
                    nidx_reg   <= '0;
                    status_reg <= STAT_OK;
                    if (item.func == FN_SAVE)
                    begin
                        if (full)
                            status_reg <= STAT_FULL;
                        else if (pend_ovf)
                            status_reg <= STAT_DEG_OVF;
                        else if (item.last_coef)
                            nidx_reg <= PW'(count_reg);
                    end
                    else if (op_in && bad_idx)
                        status_reg <= STAT_BAD_INDEX;
                end
            end
            S_DEG_B:   da_reg <= dg_rd_reg;
            S_DEG_CHK: db_reg <= dg_rd_reg;
            S_DISPATCH:
            begin
                acc_reg   <= '0;
                k_reg     <= da_reg;
                deg_reg   <= DW'(deg_calc);
                phase_reg <= 2'd0;
                bank_reg  <= 1'b0;
                first_reg <= 1'b1;
                i_reg     <= da_reg;
                r_reg     <= '0;
                if (func_reg != FN_EVAL)
                begin
                    if (full)
                        status_reg <= STAT_FULL;
                    else if (deg_ovf)
                        status_reg <= STAT_DEG_OVF;
                end
            end
            S_PLAN:
            begin
                k_reg        <= '0;
                j_reg        <= '0;
                klo_reg      <= '0;
                src_coef_reg <= 1'b1;
                src_poly_reg <= a_reg;
                jhi_reg      <= '0;
                khi_reg      <= da_reg;
                msel_reg     <= M_ONE;
                if (func_reg == FN_COMPOSE)
                begin
                    if (phase_reg == 2'd1)
                    begin
                        if (first_reg)
                            phase_reg <= 2'd2;
                        src_coef_reg <= 1'b0;
                        khi_reg      <= r_reg;
                        msel_reg     <= M_COEF;
                        jhi_reg      <= db_reg;
                    end
                    else if (phase_reg == 2'd2)
                    begin
                        k_reg   <= i_reg;
                        klo_reg <= i_reg;
                        khi_reg <= i_reg;
                    end
                    else if (phase_reg == 2'd3)
                    begin
                        bank_reg  <= ~bank_reg;
                        first_reg <= 1'b0;
                        r_reg     <= first_reg ? '0 : DW'(r_reg + db_reg);
                        if (i_reg != '0)
                        begin
                            i_reg     <= i_reg - DW'(1);
                            phase_reg <= 2'd0;
                        end
                    end
                end
                else if (phase_reg == 2'd1)
                begin
                    if (func_reg == FN_SCALE)
                        msel_reg <= M_OPV;
                    else if (func_reg == FN_MUL)
                    begin
                        msel_reg <= M_COEF;
                        jhi_reg  <= db_reg;
                    end
                end
                else if (func_reg == FN_SUM && phase_reg == 2'd2)
                begin
                    src_poly_reg <= b_reg;
                    khi_reg      <= db_reg;
                end
                else if (phase_reg != 2'd0)
                    bank_reg <= ~bank_reg;
            end
            S_CLEAR:
            begin
                k_reg <= k_reg + DW'(1);
                if (k_reg == kmax)
                    phase_reg <= phase_reg + 2'd1;
            end
            S_PASS_WR:
            begin
                if (j_reg == jhi_reg)
                begin
                    j_reg <= '0;
                    if (k_reg == khi_reg)
                        phase_reg <= phase_reg + 2'd1;
                    else
                        k_reg <= k_reg + DW'(1);
                end
                else
                    j_reg <= j_reg + DW'(1);
            end
            S_EVAL_WR:
            begin
                acc_reg <= mac_sum;
                if (k_reg == '0)
                    rval_reg <= VAL_W'($signed(mac_sum));
                else
                    k_reg <= k_reg - DW'(1);
            end
            S_COMMIT_WR:
            begin
                k_reg <= k_reg + DW'(1);
                if (k_reg == deg_reg)
                    nidx_reg <= PW'(count_reg);
            end
            S_DEL_CHK: k_reg <= '0;
            S_DEL_WR:
            begin
                if (k_reg == kmax)
                begin
                    k_reg   <= '0;
                    row_reg <= row_next_idx;
                end
                else
                    k_reg <= k_reg + DW'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign idle             = (state_reg == S_IDLE);
    assign res_valid        = (state_reg == S_RESP);
    assign res.status       = status_reg;
    assign res.result_value = rval_reg;
    assign res.new_index    = IDX_W'(nidx_reg);
    assign res.table_count  = CNT_W'(count_reg);

endmodule

`default_nettype wire

@@ src/pta_checker.sv @@
`default_nettype none

module pta_checker
import pta_pkg::*;
#(
    parameter int MAX_POLYS = 8
)
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_axis_tvalid,
    input wire logic               s_axis_tready,
    input wire logic               m_axis_tvalid,
    input wire logic               m_axis_tready,
    input wire logic [TDATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready stayed high after an input word");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[40:37] <= MAX_POLYS)
        else $error("table count above capacity");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != STAT_OK |-> m_axis_tdata[36:2] == '0)
        else $error("failed word carries value or index");

endmodule

bind polynomial_table_alu_top pta_checker #(.MAX_POLYS(MAX_POLYS)) u_pta_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
